// File: sv/i2cbe_pkg.sv
`timescale 1ns / 1ps

package i2cbe_pkg;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_WAIT  = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   typedef enum logic [5:0] {
      OP_IDLE  = 6'b000001,
      OP_START = 6'b000010,
      OP_STOP  = 6'b000100,
      OP_WRITE = 6'b001000,
      OP_WAIT  = 6'b010000,
      OP_READ  = 6'b100000
   } op_type;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
   localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd100;

   localparam logic [4:0] READ_BIT_STEPS = 5'd24;
   localparam logic [4:0] READ_ACK_STEP  = 5'd24;
   localparam logic [4:0] READ_ACKH_STEP = 5'd25;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   function automatic logic [4:0] phase_count(op_type op);
      logic [4:0] n;
      case (op)
         OP_START: n = 5'd4;
         OP_STOP:  n = 5'd3;
         OP_WRITE: n = 5'd16;
         OP_WAIT:  n = 5'd5;
         OP_READ:  n = 5'd27;
         default:  n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// File: sv/i2c_master_bit_engine_unit.sv
`timescale 1ns / 1ps
// Each result is registered when its item is accepted and is shown on rsp_tdata in the next cycle.
// Throughput: one item per cycle; req_tready stays high while the output register
// is empty or being drained in the same cycle.
// Phase tick counter: each timed SCL/SDA phase lasts phase_ticks ticks (one tick if zero).
// Synchronous active-high reset: engine idle, both lines high, registers at defaults.

module i2c_master_bit_engine_unit
   import i2cbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // write_data[7:0], send_ack, sda_in, zero pad
   input  logic [2:0]            req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // scl_level, sda_level, busy_res, done_res,
                                             // read_byte[7:0], no_ack, zero pad
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_timeout_ff;

   op_type      op_ff, op_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  sub_ff, sub_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  wcnt_ff, wcnt_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_latch_ff, ack_latch_in;
   logic [7:0]  read_hold_ff, read_hold_in;
   logic        no_ack_ff, no_ack_in;
   logic        done_in;

   logic        rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   cmd_type     cmd;
   logic [7:0]  wdata;
   logic        sack;
   logic        sda_smp;
   logic        accept;
   logic [15:0] limit;
   logic [16:0] tick_nxt;
   logic        enter;
   logic [4:0]  est;
   logic        finish;
   logic [4:0]  stop_st;

   assign cmd     = cmd_type'(req_tuser);
   assign wdata   = req_tdata[7:0];
   assign sack    = req_tdata[8];
   assign sda_smp = req_tdata[9];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign limit      = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign tick_nxt   = {1'b0, tick_ff} + 17'd1;

   always_comb begin
      op_in        = op_ff;
      step_in      = step_ff;
      sub_in       = sub_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      wcnt_in      = wcnt_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_latch_in = ack_latch_ff;
      read_hold_in = read_hold_ff;
      no_ack_in    = no_ack_ff;
      done_in      = 1'b0;
      enter        = 1'b0;
      est          = 5'd0;
      finish       = 1'b0;
      stop_st      = 5'd0;

      if (op_ff == OP_IDLE) begin
         if (cmd == CMD_START || cmd == CMD_STOP || cmd == CMD_WRITE ||
             cmd == CMD_WAIT || cmd == CMD_READ) begin
            case (cmd)
               CMD_START: op_in = OP_START;
               CMD_STOP:  op_in = OP_STOP;
               CMD_WRITE: op_in = OP_WRITE;
               CMD_WAIT:  op_in = OP_WAIT;
               default:   op_in = OP_READ;
            endcase
            step_in      = 5'd0;
            sub_in       = 2'd0;
            tick_in      = 16'd0;
            wcnt_in      = 8'd0;
            ack_latch_in = sack;
            shift_in     = (cmd == CMD_WRITE) ? wdata : 8'd0;
            if (cmd == CMD_WAIT) begin
               no_ack_in = 1'b0;
            end
            enter = 1'b1;
            est   = 5'd0;
         end
      end else if (cmd == CMD_TICK) begin
         if (op_ff == OP_WAIT && step_ff == 5'd1) begin
            if (!sda_smp) begin
               scl_in = 1'b0;
               finish = 1'b1;
            end else if (wcnt_ff >= ack_timeout_ff) begin
               step_in = 5'd2;
               tick_in = 16'd0;
               enter   = 1'b1;
               est     = 5'd2;
            end else begin
               wcnt_in = wcnt_ff + 8'd1;
            end
         end else if (tick_nxt >= {1'b0, limit}) begin
            tick_in = 16'd0;
            if (op_ff == OP_READ && step_ff < READ_BIT_STEPS && sub_ff == 2'd1) begin
               shift_in = {shift_ff[6:0], sda_smp};
            end
            step_in = step_ff + 5'd1;
            sub_in  = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
            if (step_in >= phase_count(op_ff)) begin
               if (op_ff == OP_WAIT) begin
                  no_ack_in = 1'b1;
               end
               finish = 1'b1;
            end else begin
               enter = 1'b1;
               est   = step_in;
            end
         end else begin
            tick_in = tick_nxt[15:0];
         end
      end

      if (enter) begin
         stop_st = (op_in == OP_WAIT) ? est - 5'd2 : est;
         case (op_in)
            OP_START: begin
               case (est)
                  5'd0:    sda_in = 1'b1;
                  5'd1:    scl_in = 1'b1;
                  5'd2:    sda_in = 1'b0;
                  default: scl_in = 1'b0;
               endcase
            end
            OP_STOP, OP_WAIT: begin
               if (op_in == OP_WAIT && est == 5'd0) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (op_in == OP_WAIT && est == 5'd1) begin
                  scl_in = scl_in;
               end else if (stop_st == 5'd0) begin
                  sda_in = 1'b0;
               end else if (stop_st == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (!est[0]) begin
                  sda_in   = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
                  scl_in   = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_READ: begin
               if (est < READ_BIT_STEPS) begin
                  if (sub_in == 2'd0) begin
                     scl_in = 1'b0;
                     sda_in = 1'b1;
                  end else if (sub_in == 2'd1) begin
                     scl_in = 1'b1;
                  end
               end else if (est == READ_ACK_STEP) begin
                  scl_in = 1'b0;
                  sda_in = !ack_latch_in;
               end else if (est == READ_ACKH_STEP) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            default: begin
               scl_in = scl_in;
            end
         endcase
      end

      if (finish) begin
         if (op_ff == OP_READ) begin
            read_hold_in = shift_in;
         end
         op_in   = OP_IDLE;
         step_in = 5'd0;
         sub_in  = 2'd0;
         tick_in = 16'd0;
         done_in = 1'b1;
      end

      rsp_data_in = {{(RSP_DATA_W-13){1'b0}}, no_ack_in, read_hold_in, done_in,
                     (op_in != OP_IDLE), sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_PHASE_TICKS) begin
            phase_ticks_ff <= csr_wdata;
         end else if (csr_index == CSR_ACK_TIMEOUT) begin
            ack_timeout_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         step_ff      <= 5'd0;
         sub_ff       <= 2'd0;
         tick_ff      <= 16'd0;
         shift_ff     <= 8'd0;
         wcnt_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_latch_ff <= 1'b0;
         read_hold_ff <= 8'd0;
         no_ack_ff    <= 1'b0;
      end else if (accept) begin
         op_ff        <= op_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         wcnt_ff      <= wcnt_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_latch_ff <= ack_latch_in;
         read_hold_ff <= read_hold_in;
         no_ack_ff    <= no_ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[3] |-> !rsp_data_ff[2])
      else $error("done result reports busy");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_IDLE |-> step_ff == 5'd0 && tick_ff == 16'd0)
      else $error("idle engine holds phase progress");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      op_ff != OP_IDLE |-> step_ff < phase_count(op_ff))
      else $error("phase step past end of command");

   a_no_ack_src: assert property (@(posedge clock) disable iff (reset)
      $rose(no_ack_ff) |-> $past(op_ff) == OP_WAIT && op_ff == OP_IDLE)
      else $error("no-ack set outside acknowledge wait completion");

endmodule

// File: sim/i2c_master_bit_engine_unit_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_unit_tb;
   import i2cbe_pkg::*;

   localparam int READ_DATA_PHASES = 24;
   localparam int READ_ACK_PHASE   = 24;
   localparam int READ_ACK_HIGH    = 25;
   localparam int POLL_PHASE       = 1;
   localparam int WAIT_STOP_BASE   = 2;

   typedef struct packed {
      logic       no_ack;
      logic [7:0] read_byte;
      logic       done;
      logic       busy;
      logic       sda;
      logic       scl;
   } bus_status_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [2:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_index;
   logic [15:0]           csr_wdata;

   i2c_master_bit_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // engine mirror
   cmd_type     eng_op;
   logic [4:0]  eng_step;
   int unsigned eng_ticks;
   logic [7:0]  eng_shift;
   logic [7:0]  eng_polls;
   logic        pin_scl;
   logic        pin_sda;
   logic        nack_flag;
   logic        ack_choice;
   logic [7:0]  last_read;
   logic [15:0] cfg_phase_ticks;
   logic [7:0]  cfg_ack_timeout;

   bus_status_type expected_bus_q[$];
   int          fail_count = 0;
   int          items_sent;
   int          results_checked = 0;
   int          done_count[8];
   int          nack_count;
   bit          gaps_on;
   int          stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[i2c_master_bit_engine_unit] ERROR");
      $finish;
   end

   function automatic logic [4:0] steps_of(cmd_type op);
      case (op)
         CMD_START: return 5'd4;
         CMD_STOP:  return 5'd3;
         CMD_WRITE: return 5'd16;
         CMD_WAIT:  return 5'd5;
         CMD_READ:  return 5'd27;
         default:   return 5'd0;
      endcase
   endfunction

   function automatic void stop_phase(int st);
      if (st == 0) pin_sda = 1'b0;
      else if (st == 1) pin_scl = 1'b1;
      else pin_sda = 1'b1;
   endfunction

   function automatic void enter_phase(cmd_type op, int st);
      case (op)
         CMD_START: begin
            if (st == 0) pin_sda = 1'b1;
            else if (st == 1) pin_scl = 1'b1;
            else if (st == 2) pin_sda = 1'b0;
            else pin_scl = 1'b0;
         end
         CMD_STOP: stop_phase(st);
         CMD_WRITE: begin
            if (st % 2 == 0) begin
               pin_sda = eng_shift[7];
               eng_shift = {eng_shift[6:0], 1'b0};
               pin_scl = 1'b1;
            end else begin
               pin_scl = 1'b0;
            end
         end
         CMD_WAIT: begin
            if (st == 0) begin
               pin_sda = 1'b1;
               pin_scl = 1'b1;
            end else if (st >= WAIT_STOP_BASE) begin
               stop_phase(st - WAIT_STOP_BASE);
            end
         end
         CMD_READ: begin
            if (st < READ_DATA_PHASES) begin
               if (st % 3 == 0) begin
                  pin_scl = 1'b0;
                  pin_sda = 1'b1;
               end else if (st % 3 == 1) begin
                  pin_scl = 1'b1;
               end
            end else if (st == READ_ACK_PHASE) begin
               pin_scl = 1'b0;
               pin_sda = ~ack_choice;
            end else if (st == READ_ACK_HIGH) begin
               pin_scl = 1'b1;
            end else begin
               pin_scl = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic bus_status_type engine_advance(logic [2:0] cmd, logic [7:0] wdata,
                                                     logic sack, logic sda_in);
      bus_status_type res;
      logic           finish;
      int unsigned    limit;
      res = '0;
      finish = 1'b0;
      if (eng_op == CMD_TICK) begin
         if (cmd >= CMD_START && cmd <= CMD_READ) begin
            eng_op = cmd_type'(cmd);
            eng_step = '0;
            eng_ticks = 0;
            eng_polls = '0;
            ack_choice = sack;
            eng_shift = (eng_op == CMD_WRITE) ? wdata : 8'h00;
            if (eng_op == CMD_WAIT) nack_flag = 1'b0;
            enter_phase(eng_op, 0);
         end
      end else if (cmd == CMD_TICK) begin
         if (eng_op == CMD_WAIT && eng_step == POLL_PHASE) begin
            if (!sda_in) begin
               pin_scl = 1'b0;
               finish = 1'b1;
            end else if (eng_polls >= cfg_ack_timeout) begin
               eng_step = 5'(WAIT_STOP_BASE);
               eng_ticks = 0;
               enter_phase(eng_op, eng_step);
            end else begin
               eng_polls = eng_polls + 8'd1;
            end
         end else begin
            limit = (cfg_phase_ticks == 0) ? 1 : cfg_phase_ticks;
            eng_ticks = eng_ticks + 1;
            if (eng_ticks >= limit) begin
               eng_ticks = 0;
               if (eng_op == CMD_READ && eng_step < READ_DATA_PHASES && eng_step % 3 == 1)
                  eng_shift = {eng_shift[6:0], sda_in};
               eng_step = eng_step + 5'd1;
               if (eng_step >= steps_of(eng_op)) begin
                  if (eng_op == CMD_WAIT) begin
                     nack_flag = 1'b1;
                     nack_count++;
                  end
                  finish = 1'b1;
               end else begin
                  enter_phase(eng_op, eng_step);
               end
            end
         end
         if (finish) begin
            if (eng_op == CMD_READ) last_read = eng_shift;
            done_count[eng_op]++;
            eng_op = CMD_TICK;
            eng_step = '0;
            eng_ticks = 0;
            res.done = 1'b1;
         end
      end
      res.scl = pin_scl;
      res.sda = pin_sda;
      res.busy = (eng_op != CMD_TICK);
      res.read_byte = last_read;
      res.no_ack = nack_flag;
      return res;
   endfunction

   // result side: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      bus_status_type want;
      bus_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(bus_status_type)-1:0];
         if (expected_bus_q.size() == 0) begin
            $error("rsp transfer with nothing expected: 0x%0h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_bus_q.pop_front();
            results_checked++;
            check_field("scl_level", want.scl, got.scl);
            check_field("sda_level", want.sda, got.sda);
            check_field("busy_res", want.busy, got.busy);
            check_field("done_res", want.done, got.done);
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("no_ack", want.no_ack, got.no_ack);
         end
      end
   end

   task automatic send_item(logic [2:0] cmd, logic [7:0] wdata, logic sack, logic sda);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-10){1'b0}}, sda, sack, wdata};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_bus_q.push_back(engine_advance(cmd, wdata, sack, sda));
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bus_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      wait_drained();
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PHASE_TICKS) cfg_phase_ticks = val;
      else cfg_ack_timeout = val[7:0];
   endtask

   // issue one command, then tick until the engine goes idle, with random other items when noisy
   task automatic run_command(logic [2:0] cmd, logic [7:0] wdata, logic sack,
                              int low_pct, bit noisy);
      send_item(cmd, wdata, sack, 1'($urandom_range(0, 1)));
      while (eng_op != CMD_TICK) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_item(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1);
      end
   endtask

   task automatic test_ignored_inputs();
      send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
      send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);
      send_item(3'd6, 8'hA5, 1'b1, 1'b0);
      send_item(3'd7, 8'h5A, 1'b0, 1'b1);
   endtask

   task automatic test_each_command();
      run_command(CMD_START, 8'h00, 1'b0, 50, 0);
      run_command(CMD_WRITE, 8'hFF, 1'b0, 50, 0);
      run_command(CMD_WRITE, 8'h00, 1'b1, 50, 0);
      run_command(CMD_WAIT, 8'h00, 1'b0, 30, 0);
      run_command(CMD_READ, 8'h00, 1'b1, 50, 0);
      run_command(CMD_READ, 8'h00, 1'b0, 0, 0);
      run_command(CMD_READ, 8'h00, 1'b1, 100, 0);
      run_command(CMD_WRITE, 8'hA5, 1'b0, 50, 1);
      run_command(CMD_STOP, 8'h00, 1'b0, 50, 1);
   endtask

   task automatic test_phase_lengths();
      csr_write(CSR_PHASE_TICKS, 16'd0);
      run_command(CMD_START, 8'h3C, 1'b0, 50, 0);
      csr_write(CSR_PHASE_TICKS, 16'd3);
      run_command(CMD_WRITE, 8'h96, 1'b0, 50, 1);
      csr_write(CSR_PHASE_TICKS, 16'd2);
      run_command(CMD_READ, 8'h00, 1'b1, 50, 1);
      csr_write(CSR_PHASE_TICKS, 16'd1);
   endtask

   task automatic test_ack_timeout();
      run_command(CMD_WAIT, 8'h00, 1'b0, 0, 0);
      csr_write(CSR_ACK_TIMEOUT, 8'd0);
      run_command(CMD_WAIT, 8'h00, 1'b0, 0, 0);
      run_command(CMD_WAIT, 8'h00, 1'b0, 100, 0);
      csr_write(CSR_PHASE_TICKS, 16'd2);
      csr_write(CSR_ACK_TIMEOUT, 8'd3);
      run_command(CMD_WAIT, 8'h00, 1'b1, 0, 1);
      csr_write(CSR_PHASE_TICKS, 16'd1);
      csr_write(CSR_ACK_TIMEOUT, 8'd255);
      run_command(CMD_WAIT, 8'h00, 1'b0, 0, 0);
      run_command(CMD_WAIT, 8'h00, 1'b0, 2, 0);
   endtask

   // hold a phase at the longest length for a while, then shorten it mid-phase
   task automatic test_long_phase();
      gaps_on = 1'b0;
      csr_write(CSR_PHASE_TICKS, 16'hFFFF);
      send_item(CMD_STOP, 8'h00, 1'b0, 1'b1);
      repeat (40) send_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
      csr_write(CSR_PHASE_TICKS, 16'd1);
      while (eng_op != CMD_TICK) send_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic(int n_items);
      int       stop_at;
      int       n_cmds;
      logic [2:0] cmd;
      stop_at = items_sent + n_items;
      n_cmds = 0;
      while (items_sent < stop_at) begin
         n_cmds++;
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 7) == 0)
               csr_write(CSR_PHASE_TICKS, 16'($urandom_range(5, 12)));
            else
               csr_write(CSR_PHASE_TICKS, 16'($urandom_range(0, 3)));
            csr_write(CSR_ACK_TIMEOUT, ($urandom_range(0, 9) == 0) ? 8'd255
                                                                  : 8'($urandom_range(0, 6)));
         end
         if (n_cmds % 20 == 0) wait_drained();
         if ($urandom_range(0, 9) == 0) begin
            cmd = ($urandom_range(0, 2) == 0) ? CMD_TICK : 3'($urandom_range(6, 7));
            send_item(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            run_command(3'($urandom_range(1, 5)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), $urandom_range(5, 60), 1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b1;
      items_sent = 0;
      nack_count = 0;
      foreach (done_count[i]) done_count[i] = 0;
      eng_op = CMD_TICK;
      eng_step = '0;
      eng_ticks = 0;
      eng_shift = '0;
      eng_polls = '0;
      pin_scl = 1'b1;
      pin_sda = 1'b1;
      nack_flag = 1'b0;
      ack_choice = 1'b0;
      last_read = '0;
      cfg_phase_ticks = PHASE_TICKS_RST;
      cfg_ack_timeout = ACK_TIMEOUT_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_inputs();
      test_each_command();
      test_phase_lengths();
      test_ack_timeout();
      test_long_phase();
      test_random_traffic(120);
      wait_drained();
      gaps_on = 1'b0;
      test_random_traffic(50);

      wait_drained();
      repeat (4) @(posedge clock);
      $display("%0d transfers in, %0d results checked, %0d no-ack timeouts",
               items_sent, results_checked, nack_count);
      $display("completed start %0d, stop %0d, write %0d, wait-ack %0d, read %0d",
               done_count[CMD_START], done_count[CMD_STOP], done_count[CMD_WRITE],
               done_count[CMD_WAIT], done_count[CMD_READ]);
      if (fail_count == 0)
         $display("[i2c_master_bit_engine_unit] OK");
      else
         $display("[i2c_master_bit_engine_unit] ERROR");
      $finish;
   end

endmodule
